/* rtl/core/angle_speed_lowpass_estimator_macros.svh */
// assertion macros used by the estimator controller
`ifndef ANGLE_SPEED_LOWPASS_ESTIMATOR_MACROS_SVH
`define ANGLE_SPEED_LOWPASS_ESTIMATOR_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define ASLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define ASLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/asle_pkg.sv */
// package: widths, register codes, reset values, command types and helpers
`timescale 1ns / 1ps

package asle_pkg;

    // angle and speed widths
    localparam int ANGLE_BITS = 15;
    localparam int DIFF_W     = ANGLE_BITS + 1;
    localparam int SPEED_W    = 24;
    localparam int COEF_W     = 18;
    localparam int SCALE_W    = 24;

    // configuration port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_NEW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_OLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 2'd2;

    localparam logic [COEF_W-1:0]  COEF_NEW_RST    = 18'd7749;
    localparam logic [COEF_W-1:0]  COEF_OLD_RST    = 18'd123323;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 24'd120000;

    // shared multiplier and accumulator
    localparam int MUL_W     = 25;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int X_FRAC    = 8;
    localparam int COEF_FRAC = 17;

    localparam logic [1:0] MUL_SEL_SCALE = 2'd0;
    localparam logic [1:0] MUL_SEL_NEW   = 2'd1;
    localparam logic [1:0] MUL_SEL_OLD   = 2'd2;

    localparam logic signed [ACC_W-1:0] SPD_HI = ACC_W'((64'sd1 <<< (SPEED_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SPD_LO = ACC_W'(-(64'sd1 <<< (SPEED_W - 1)));

    // controller to datapath
    typedef struct packed {
        logic       take;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       x_en;
        logic       acc_en;
        logic       fin;
    } asle_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic have_prior;
        logic out_free;
    } asle_status_t;

    // clamp a wide signed value to the speed range
    function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > SPD_HI)
        begin
            r = SPD_HI;
        end
        else if (v < SPD_LO)
        begin
            r = SPD_LO;
        end
        else
        begin
            r = v;
        end
        return r[SPEED_W-1:0];
    endfunction

endpackage

/* rtl/core/asle_if.sv */
// valid/ready channel interfaces for angle input words and speed output words
`timescale 1ns / 1ps

interface asle_angle_if
    import asle_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface

interface asle_speed_if
    import asle_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed;

    modport source (output valid, output speed, input ready);
    modport sink (input valid, input speed, output ready);
endinterface

/* rtl/core/asle_ctrl.sv */
// controller: sequences one angle word through the shared multiplier
`timescale 1ns / 1ps
`include "angle_speed_lowpass_estimator_macros.svh"

module asle_ctrl
    import asle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  asle_status_t status,
    output asle_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_P = 3'd1;
    localparam logic [2:0] ST_SAT_X = 3'd2;
    localparam logic [2:0] ST_MUL_N = 3'd3;
    localparam logic [2:0] ST_MUL_O = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       take;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_SEL_SCALE;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = take;
                if (take)
                begin
                    // first word only records the angle
                    state_next = status.have_prior ? ST_MUL_P : ST_FIN;
                end
            end
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEL_SCALE;
                state_next  = ST_SAT_X;
            end
            ST_SAT_X:
            begin
                cmd.x_en   = 1'b1;
                state_next = ST_MUL_N;
            end
            ST_MUL_N:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEL_NEW;
                state_next  = ST_MUL_O;
            end
            ST_MUL_O:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEL_OLD;
                cmd.acc_en  = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // wait for room in the output register
                if (status.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASLE_ASSERT_NEXT(a_take_leaves_idle, take, state_reg != ST_IDLE, "accepted word did not start")
    `ASLE_ASSERT_NEXT(a_fin_holds, (state_reg == ST_FIN) && !status.out_free, state_reg == ST_FIN, "result dropped while output full")
    `ASLE_ASSERT_NOW(a_mul_p_from_idle, state_reg == ST_MUL_P, $past(state_reg) == ST_IDLE, "scale multiply entered out of order")
    `ASLE_ASSERT_NOW(a_fin_only_when_free, cmd.fin, status.out_free, "result written over waiting word")

endmodule

/* rtl/core/asle_dp.sv */
// datapath: config registers, angle difference, shared multiplier, filter state
`timescale 1ns / 1ps

module asle_dp
    import asle_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic [ANGLE_BITS-1:0]     angle,
    input  asle_cmd_t                 cmd,
    output asle_status_t              status,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SPEED_W-1:0] speed
);

    localparam logic signed [DIFF_W-1:0] HALF = DIFF_W'(1) << (ANGLE_BITS - 1);
    localparam logic signed [DIFF_W-1:0] FULL = DIFF_W'(1) << ANGLE_BITS;
    localparam logic signed [PROD_W-1:0] X_ROUND = PROD_W'(1) << (X_FRAC - 1);
    localparam logic signed [ACC_W-1:0]  Y_ROUND = ACC_W'(1) << (COEF_FRAC - 1);

    logic [COEF_W-1:0]          coef_new_reg;
    logic [COEF_W-1:0]          coef_old_reg;
    logic [SCALE_W-1:0]         scale_reg;
    logic [ANGLE_BITS-1:0]      prior_reg;
    logic                       have_prior_reg;
    logic                       first_reg;
    logic signed [DIFF_W-1:0]   d_reg;
    logic signed [DIFF_W-1:0]   d_raw;
    logic signed [DIFF_W-1:0]   d_next;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]   x_round;
    logic signed [PROD_W-1:0]   x_shift;
    logic signed [SPEED_W-1:0]  x_reg;
    logic signed [ACC_W-1:0]    y_sum;
    logic signed [ACC_W-1:0]    y_shift;
    logic signed [SPEED_W-1:0]  y_sat;
    logic signed [SPEED_W-1:0]  filt_reg;
    logic                       out_valid_reg;
    logic signed [SPEED_W-1:0]  speed_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_new_reg <= COEF_NEW_RST;
            coef_old_reg <= COEF_OLD_RST;
            scale_reg    <= SPEED_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEF_NEW:    coef_new_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_OLD:    coef_old_reg <= cfg_data[COEF_W-1:0];
                CFG_SPEED_SCALE: scale_reg    <= cfg_data[SCALE_W-1:0];
                default:         ;
            endcase
        end
    end

    // wrapped angle difference, exact half turns kept
    always_comb
    begin
        d_raw = $signed({1'b0, angle}) - $signed({1'b0, prior_reg});
        if (d_raw > HALF)
        begin
            d_next = d_raw - FULL;
        end
        else if (d_raw < -HALF)
        begin
            d_next = d_raw + FULL;
        end
        else
        begin
            d_next = d_raw;
        end
    end

    // angle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg      <= '0;
            have_prior_reg <= 1'b0;
            first_reg      <= 1'b0;
        end
        else if (cmd.take)
        begin
            prior_reg      <= angle;
            have_prior_reg <= 1'b1;
            first_reg      <= !have_prior_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            d_reg <= d_next;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SEL_SCALE:
            begin
                mul_a = MUL_W'(d_reg);
                mul_b = $signed(MUL_W'(scale_reg));
            end
            MUL_SEL_NEW:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = $signed(MUL_W'(coef_new_reg));
            end
            MUL_SEL_OLD:
            begin
                mul_a = MUL_W'(filt_reg);
                mul_b = $signed(MUL_W'(coef_old_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product and accumulator registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= prod_reg;
        end
    end

    // rpm in q8, rounded half up and clamped
    assign x_round = prod_reg + X_ROUND;
    assign x_shift = x_round >>> X_FRAC;

    always_ff @(posedge clk)
    begin
        if (cmd.x_en)
        begin
            x_reg <= sat_speed(ACC_W'(x_shift));
        end
    end

    // filter sum, rounded half up and clamped
    assign y_sum   = ACC_W'(acc_reg) + ACC_W'(prod_reg) + Y_ROUND;
    assign y_shift = y_sum >>> COEF_FRAC;
    assign y_sat   = sat_speed(y_shift);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
        end
        else if (cmd.fin && !first_reg)
        begin
            filt_reg <= y_sat;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            speed_reg <= first_reg ? '0 : y_sat;
        end
    end

    assign out_valid         = out_valid_reg;
    assign speed             = speed_reg;
    assign status.have_prior = have_prior_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

/* rtl/core/angle_speed_lowpass_estimator.sv */
// Rotor speed estimator: each angle word gives one filtered speed word (signed Q15.8 rpm).
// One word is worked at a time. A word with a prior angle has its difference registered at
// acceptance, then takes three passes through the one shared 25x25 multiplier (difference
// times scale, clamped; new-value weight; old-value weight) and the final sum goes to the
// output register; the very first word after reset gives speed 0. The next word is
// accepted the cycle after a result is loaded, even while that result still waits to be
// taken. The user must make configuration writes only with no word in flight (unenforced).
`timescale 1ns / 1ps

module angle_speed_lowpass_estimator
    import asle_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    asle_angle_if.sink           angle_ch,
    asle_speed_if.source         speed_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    asle_cmd_t    cmd;
    asle_status_t status;
    logic         in_ready;

    // sequencer
    asle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (angle_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    asle_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .angle     (angle_ch.angle),
        .cmd       (cmd),
        .status    (status),
        .out_valid (speed_ch.valid),
        .out_ready (speed_ch.ready),
        .speed     (speed_ch.speed)
    );

    assign angle_ch.ready = in_ready;

endmodule
